// File: sv/pwfr_pkg.sv
`timescale 1ns / 1ps

package pwfr_pkg;

   // Field widths
   localparam int TIME_W  = 32;
   localparam int CSR_W   = 16;
   localparam int EDGE_W  = CSR_W + 1;
   localparam int CSR_IDX_W = 3;
   localparam int PHASE_W = 2;
   localparam int COUNT_W = 7;

   localparam int MAX_BYTES_DEFAULT = 64;

   // Tolerances around the nominal widths
   localparam int START_TOL = 20;
   localparam int BIT_TOL   = 15;
   localparam int END_TOL   = 20;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_PULSE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_PULSE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_PULSE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_END_PULSE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BIT_THRESH  = 3'd4;

   // Register reset values
   localparam int START_RST  = 150;
   localparam int ZERO_RST   = 40;
   localparam int ONE_RST    = 70;
   localparam int END_RST    = 100;
   localparam int THRESH_RST = 55;

   // Phase codes on the result word
   localparam logic [PHASE_W-1:0] PHASE_IDLE  = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_DATA  = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_ENDED = 2'd2;

   typedef enum logic [1:0] {
      KIND_CLEAR = 2'd0,
      KIND_RISE  = 2'd1,
      KIND_FALL  = 2'd2
   } kind_type;

   // Queued event between front and back
   typedef struct packed {
      kind_type            kind;
      logic [TIME_W-1:0]   time_us;
   } event_type;

   // Precomputed window edges
   typedef struct packed {
      logic [CSR_W-1:0]  start_lo;
      logic [EDGE_W-1:0] start_hi;
      logic [CSR_W-1:0]  zero_lo;
      logic [EDGE_W-1:0] one_hi;
      logic [CSR_W-1:0]  end_lo;
      logic [CSR_W-1:0]  thresh;
   } window_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic               byte_valid;
      logic [7:0]         byte_value;
      logic               frame_started;
      logic               frame_done;
      logic               frame_aborted;
      logic [COUNT_W-1:0] bytes_received;
   } rsp_type;

   function automatic logic [CSR_W-1:0] sat_sub(input logic [CSR_W-1:0] a, input int b);
      logic [CSR_W-1:0] bb;
      bb = CSR_W'(b);
      return (a >= bb) ? a - bb : '0;
   endfunction

   function automatic logic [EDGE_W-1:0] add_tol(input logic [CSR_W-1:0] a, input int b);
      return EDGE_W'(a) + EDGE_W'(b);
   endfunction

endpackage

// File: sv/pwfr_if.sv
`timescale 1ns / 1ps

interface pwfr_req_if;
   logic                          valid;
   logic                          ready;
   logic                          command;
   logic                          line_level;
   logic [pwfr_pkg::TIME_W-1:0]   time_us;

   modport source (output valid, output command, output line_level, output time_us,
                   input ready);
   modport sink   (input valid, input command, input line_level, input time_us,
                   output ready);
endinterface

interface pwfr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pwfr_pkg::PHASE_W-1:0]  phase;
   logic                          byte_valid;
   logic [7:0]                    byte_value;
   logic                          frame_started;
   logic                          frame_done;
   logic                          frame_aborted;
   logic [pwfr_pkg::COUNT_W-1:0]  bytes_received;

   modport source (output valid, output phase, output byte_valid, output byte_value,
                   output frame_started, output frame_done, output frame_aborted,
                   output bytes_received, input ready);
   modport sink   (input valid, input phase, input byte_valid, input byte_value,
                   input frame_started, input frame_done, input frame_aborted,
                   input bytes_received, output ready);
endinterface

// File: sv/pwfr_csr.sv
`timescale 1ns / 1ps

// Config registers, held as ready-made window edges
module pwfr_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [pwfr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pwfr_pkg::CSR_W-1:0]        csr_wdata,
   output pwfr_pkg::window_type              win
);

   pwfr_pkg::window_type win_ff, win_in;

   always_comb begin
      win_in = win_ff;
      if (csr_we) begin
         case (csr_index)
            pwfr_pkg::CSR_START_PULSE: begin
               win_in.start_lo = pwfr_pkg::sat_sub(csr_wdata, pwfr_pkg::START_TOL);
               win_in.start_hi = pwfr_pkg::add_tol(csr_wdata, pwfr_pkg::START_TOL);
            end
            pwfr_pkg::CSR_ZERO_PULSE:
               win_in.zero_lo = pwfr_pkg::sat_sub(csr_wdata, pwfr_pkg::BIT_TOL);
            pwfr_pkg::CSR_ONE_PULSE:
               win_in.one_hi = pwfr_pkg::add_tol(csr_wdata, pwfr_pkg::BIT_TOL);
            pwfr_pkg::CSR_END_PULSE:
               win_in.end_lo = pwfr_pkg::sat_sub(csr_wdata, pwfr_pkg::END_TOL);
            pwfr_pkg::CSR_BIT_THRESH:
               win_in.thresh = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff.start_lo <= pwfr_pkg::CSR_W'(pwfr_pkg::START_RST - pwfr_pkg::START_TOL);
         win_ff.start_hi <= pwfr_pkg::EDGE_W'(pwfr_pkg::START_RST + pwfr_pkg::START_TOL);
         win_ff.zero_lo  <= pwfr_pkg::CSR_W'(pwfr_pkg::ZERO_RST - pwfr_pkg::BIT_TOL);
         win_ff.one_hi   <= pwfr_pkg::EDGE_W'(pwfr_pkg::ONE_RST + pwfr_pkg::BIT_TOL);
         win_ff.end_lo   <= pwfr_pkg::CSR_W'(pwfr_pkg::END_RST - pwfr_pkg::END_TOL);
         win_ff.thresh   <= pwfr_pkg::CSR_W'(pwfr_pkg::THRESH_RST);
      end else begin
         win_ff <= win_in;
      end
   end

   assign win = win_ff;

endmodule

// File: sv/pwfr_front.sv
`timescale 1ns / 1ps

// Accepts words, sorts them into clear / rise / fall, two-entry queue
module pwfr_front (
   input  logic                  clock,
   input  logic                  reset,
   pwfr_req_if.sink              req_ch,
   output logic                  q_valid,
   output pwfr_pkg::event_type   q_event,
   input  logic                  q_pop
);

   pwfr_pkg::event_type mem_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;
   logic                push;
   pwfr_pkg::event_type ev;

   assign req_ch.ready = (count_ff != 2'd2);
   assign push         = req_ch.valid && req_ch.ready;

   always_comb begin
      if (req_ch.command)
         ev.kind = pwfr_pkg::KIND_CLEAR;
      else if (req_ch.line_level)
         ev.kind = pwfr_pkg::KIND_RISE;
      else
         ev.kind = pwfr_pkg::KIND_FALL;
      ev.time_us = req_ch.time_us;
   end

   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wr_ptr_ff] <= ev;
   end

   assign q_valid = (count_ff != 2'd0);
   assign q_event = mem_ff[rd_ptr_ff];

endmodule

// File: sv/pwfr_back.sv
`timescale 1ns / 1ps

// Receiver state machine and result register
module pwfr_back #(
   parameter int MAX_BYTES = pwfr_pkg::MAX_BYTES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pwfr_pkg::window_type  win,
   input  logic                  q_valid,
   input  pwfr_pkg::event_type   q_event,
   output logic                  q_pop,
   pwfr_rsp_if.source            rsp_ch
);

   localparam int CNT_W = $clog2(MAX_BYTES + 1);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_DATA  = 3'b010,
      ST_ENDED = 3'b100
   } phase_type;

   phase_type                      phase_ff, phase_in;
   logic [pwfr_pkg::TIME_W-1:0]    rise_ff, rise_in;
   logic [7:0]                     shift_ff, shift_in;
   logic [2:0]                     pos_ff, pos_in;
   logic [CNT_W-1:0]               total_ff, total_in;
   logic                           done_ff, done_in;
   logic                           out_valid_ff, out_valid_in;
   pwfr_pkg::rsp_type              out_ff, out_in;

   logic [pwfr_pkg::TIME_W-1:0]    width;
   logic                           in_start, in_bits, past_end, bit_one;
   logic [7:0]                     shift_next;
   logic                           valid, started, aborted;

   assign q_pop = q_valid && (!out_valid_ff || rsp_ch.ready);

   assign width    = q_event.time_us - rise_ff;
   assign in_start = (width >= pwfr_pkg::TIME_W'(win.start_lo)) &&
                     (width <= pwfr_pkg::TIME_W'(win.start_hi));
   assign in_bits  = (width >= pwfr_pkg::TIME_W'(win.zero_lo)) &&
                     (width <= pwfr_pkg::TIME_W'(win.one_hi));
   assign past_end = (width >= pwfr_pkg::TIME_W'(win.end_lo));
   assign bit_one  = (width >= pwfr_pkg::TIME_W'(win.thresh));
   assign shift_next = ((pos_ff == 3'd0) ? 8'd0 : shift_ff) | (8'(bit_one) << pos_ff);

   always_comb begin
      phase_in = phase_ff;
      rise_in  = rise_ff;
      shift_in = shift_ff;
      pos_in   = pos_ff;
      total_in = total_ff;
      done_in  = done_ff;
      valid    = 1'b0;
      started  = 1'b0;
      aborted  = 1'b0;

      case (q_event.kind)
         pwfr_pkg::KIND_RISE:
            rise_in = q_event.time_us;
         pwfr_pkg::KIND_FALL: begin
            case (phase_ff)
               ST_IDLE: begin
                  if (in_start) begin
                     phase_in = ST_DATA;
                     shift_in = 8'd0;
                     pos_in   = 3'd0;
                     total_in = '0;
                     started  = 1'b1;
                  end
               end
               ST_DATA: begin
                  if (in_bits) begin
                     if (total_ff < CNT_W'(MAX_BYTES)) begin
                        shift_in = shift_next;
                        if (pos_ff == 3'd7) begin
                           valid    = 1'b1;
                           total_in = total_ff + 1'b1;
                        end
                        pos_in = pos_ff + 3'd1;
                     end
                  end else if (past_end) begin
                     phase_in = ST_ENDED;
                     done_in  = 1'b1;
                  end else begin
                     aborted = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase

      // clear command, abort, or falling edge after the end pulse
      if (q_event.kind == pwfr_pkg::KIND_CLEAR || aborted ||
          (q_event.kind == pwfr_pkg::KIND_FALL && phase_ff != ST_IDLE &&
           phase_ff != ST_DATA)) begin
         phase_in = ST_IDLE;
         rise_in  = '0;
         shift_in = 8'd0;
         pos_in   = 3'd0;
         total_in = '0;
         done_in  = 1'b0;
      end
   end

   always_comb begin
      case (phase_in)
         ST_DATA:  out_in.phase = pwfr_pkg::PHASE_DATA;
         ST_ENDED: out_in.phase = pwfr_pkg::PHASE_ENDED;
         default:  out_in.phase = pwfr_pkg::PHASE_IDLE;
      endcase
      out_in.byte_valid     = valid;
      out_in.byte_value     = valid ? shift_next : 8'd0;
      out_in.frame_started  = started;
      out_in.frame_done     = done_in;
      out_in.frame_aborted  = aborted;
      out_in.bytes_received = pwfr_pkg::COUNT_W'(total_in);
      out_valid_in = q_pop ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ST_IDLE;
         rise_ff      <= '0;
         shift_ff     <= 8'd0;
         pos_ff       <= 3'd0;
         total_ff     <= '0;
         done_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            phase_ff <= phase_in;
            rise_ff  <= rise_in;
            shift_ff <= shift_in;
            pos_ff   <= pos_in;
            total_ff <= total_in;
            done_ff  <= done_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop)
         out_ff <= out_in;
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.phase          = out_ff.phase;
   assign rsp_ch.byte_valid     = out_ff.byte_valid;
   assign rsp_ch.byte_value     = out_ff.byte_value;
   assign rsp_ch.frame_started  = out_ff.frame_started;
   assign rsp_ch.frame_done     = out_ff.frame_done;
   assign rsp_ch.frame_aborted  = out_ff.frame_aborted;
   assign rsp_ch.bytes_received = out_ff.bytes_received;

endmodule

// File: sv/pulse_width_frame_receiver_unit.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake     Word
// req_ch   in   valid/ready   command, line_level, time_us
// rsp_ch   out  valid/ready   phase, byte_valid, byte_value, frame_started,
//                             frame_done, frame_aborted, bytes_received
// csr_*    in   write enable  csr_index, csr_wdata (16 bit)
//
// One word per cycle sustained while rsp_ch keeps taking results; a word taken
// on req_ch is written into the queue entry, then the back end's state update
// writes its result into the result register, from which rsp_ch takes it.
// Throughput is set by the back-end state update, which takes one queued word at a time.
// Synchronous active-high reset; no clearing pass, ready right after reset.
// A stall on rsp_ch fills the two-entry queue, then req_ch.ready drops.

module pulse_width_frame_receiver_unit #(
   parameter int MAX_BYTES = pwfr_pkg::MAX_BYTES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   pwfr_req_if.sink                          req_ch,
   pwfr_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [pwfr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pwfr_pkg::CSR_W-1:0]        csr_wdata
);

   pwfr_pkg::window_type win;     // window edges, rebuilt on each csr write
   pwfr_pkg::event_type  q_event; // head of the front-to-back queue
   logic                 q_valid;
   logic                 q_pop;

   // Config: stores edges (start +/-20, zero -15, one +15, end -20) directly
   pwfr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .win       (win)
   );

   // Front end: classify each word and queue it
   pwfr_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_valid (q_valid),
      .q_event (q_event),
      .q_pop   (q_pop)
   );

   // Back end: pulse width measure, phase machine, byte assembly, result reg
   pwfr_back #(
      .MAX_BYTES (MAX_BYTES)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .win     (win),
      .q_valid (q_valid),
      .q_event (q_event),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

// Pulse-width frame receiver testbench.
// Edge words are queued by the stimulus process and pushed out by a bursty driver.
// Each accepted word runs through a local decoder model, and each result word is
// checked against the oldest predicted result. The result side stalls on its own
// pattern, with one long hold so that the input backs up.
module testbench;

   localparam int FRAME_LIMIT   = pwfr_pkg::MAX_BYTES_DEFAULT;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_WORDS  = 30;      // per register setting
   localparam int SETTING_COUNT = 5;
   localparam int REPORT_MAX    = 10;
   localparam int DRAIN_CYCLES  = 20;     // drain margin after the last result, leave plenty
   localparam int LONG_HOLD     = 500;

   typedef struct packed {
      logic                        command;
      logic                        line_level;
      logic [pwfr_pkg::TIME_W-1:0] time_us;
   } edge_word_type;

   typedef enum int {
      ALWAYS_READY,
      MOSTLY_READY,
      MOSTLY_STALLED,
      MASK_PATTERN
   } stall_type;

   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           csr_we    = 1'b0;
   logic [pwfr_pkg::CSR_IDX_W-1:0] csr_index = pwfr_pkg::CSR_START_PULSE;
   logic [pwfr_pkg::CSR_W-1:0]     csr_wdata = '0;

   pwfr_req_if req_ch();
   pwfr_rsp_if rsp_ch();

   pulse_width_frame_receiver_unit #(
      .MAX_BYTES (FRAME_LIMIT)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Decoder model: register copy and receiver state
   // ---------------------------------------------------------------
   logic [pwfr_pkg::CSR_W-1:0]   cfg_start  = pwfr_pkg::CSR_W'(pwfr_pkg::START_RST);
   logic [pwfr_pkg::CSR_W-1:0]   cfg_zero   = pwfr_pkg::CSR_W'(pwfr_pkg::ZERO_RST);
   logic [pwfr_pkg::CSR_W-1:0]   cfg_one    = pwfr_pkg::CSR_W'(pwfr_pkg::ONE_RST);
   logic [pwfr_pkg::CSR_W-1:0]   cfg_end    = pwfr_pkg::CSR_W'(pwfr_pkg::END_RST);
   logic [pwfr_pkg::CSR_W-1:0]   cfg_thresh = pwfr_pkg::CSR_W'(pwfr_pkg::THRESH_RST);

   logic [pwfr_pkg::PHASE_W-1:0] rx_ph      = pwfr_pkg::PHASE_IDLE;
   logic [pwfr_pkg::TIME_W-1:0]  rise_time  = '0;
   logic [7:0]                   shift_reg  = '0;
   logic [2:0]                   bit_pos    = '0;
   logic [pwfr_pkg::COUNT_W-1:0] byte_count = '0;
   logic                         done_flag  = 1'b0;

   pwfr_pkg::rsp_type            decoded_q[$];    // predicted result words, oldest first

   function automatic logic [pwfr_pkg::TIME_W-1:0] floor_sub(
         input logic [pwfr_pkg::TIME_W-1:0] a, b);
      return (a >= b) ? a - b : '0;
   endfunction

   // Window edges, 32 bit so the upper edges never wrap
   function automatic logic [pwfr_pkg::TIME_W-1:0] start_lo();
      return floor_sub(pwfr_pkg::TIME_W'(cfg_start), pwfr_pkg::TIME_W'(pwfr_pkg::START_TOL));
   endfunction

   function automatic logic [pwfr_pkg::TIME_W-1:0] start_hi();
      return pwfr_pkg::TIME_W'(cfg_start) + pwfr_pkg::TIME_W'(pwfr_pkg::START_TOL);
   endfunction

   function automatic logic [pwfr_pkg::TIME_W-1:0] bit_lo();
      return floor_sub(pwfr_pkg::TIME_W'(cfg_zero), pwfr_pkg::TIME_W'(pwfr_pkg::BIT_TOL));
   endfunction

   function automatic logic [pwfr_pkg::TIME_W-1:0] bit_hi();
      return pwfr_pkg::TIME_W'(cfg_one) + pwfr_pkg::TIME_W'(pwfr_pkg::BIT_TOL);
   endfunction

   function automatic logic [pwfr_pkg::TIME_W-1:0] end_lo();
      return floor_sub(pwfr_pkg::TIME_W'(cfg_end), pwfr_pkg::TIME_W'(pwfr_pkg::END_TOL));
   endfunction

   function automatic void clear_rx();
      rx_ph      = pwfr_pkg::PHASE_IDLE;
      rise_time  = '0;
      shift_reg  = '0;
      bit_pos    = '0;
      byte_count = '0;
      done_flag  = 1'b0;
   endfunction

   function automatic pwfr_pkg::rsp_type decode_edge(input edge_word_type w);
      pwfr_pkg::rsp_type           r;
      logic [pwfr_pkg::TIME_W-1:0] width;
      logic                        bit_val;
      r     = '0;
      width = w.time_us - rise_time;    // high time, modulo 2^32
      if (w.command) begin
         clear_rx();
      end else if (w.line_level) begin
         rise_time = w.time_us;
      end else if (rx_ph == pwfr_pkg::PHASE_IDLE) begin
         if (width >= start_lo() && width <= start_hi()) begin
            rx_ph           = pwfr_pkg::PHASE_DATA;
            shift_reg       = '0;
            bit_pos         = '0;
            byte_count      = '0;
            r.frame_started = 1'b1;
         end
      end else if (rx_ph == pwfr_pkg::PHASE_DATA) begin
         // bit window wins over the end range
         if (width >= bit_lo() && width <= bit_hi()) begin
            if (byte_count < FRAME_LIMIT) begin
               bit_val = (width >= pwfr_pkg::TIME_W'(cfg_thresh));
               if (bit_pos == 3'd0) shift_reg = '0;
               shift_reg = shift_reg | (8'(bit_val) << bit_pos);
               if (bit_pos == 3'd7) begin
                  r.byte_valid = 1'b1;
                  r.byte_value = shift_reg;
                  byte_count++;
                  bit_pos = '0;
               end else begin
                  bit_pos++;
               end
            end
         end else if (width >= end_lo()) begin
            rx_ph     = pwfr_pkg::PHASE_ENDED;
            done_flag = 1'b1;
         end else begin
            clear_rx();
            r.frame_aborted = 1'b1;
         end
      end else begin
         clear_rx();          // first falling edge after the end pulse
      end
      r.phase          = rx_ph;
      r.frame_done     = done_flag;
      r.bytes_received = byte_count;
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Stimulus generation
   // ---------------------------------------------------------------
   edge_word_type               edge_words[$];     // words waiting for the driver
   int unsigned                 words_queued = 0;
   int unsigned                 words_taken  = 0;
   logic [pwfr_pkg::TIME_W-1:0] line_clock   = '0; // timestamp cursor for generated pulses

   task automatic push_word(input logic cmd, input logic lvl,
                            input logic [pwfr_pkg::TIME_W-1:0] t);
      edge_words.push_back(edge_word_type'{command: cmd, line_level: lvl, time_us: t});
      words_queued++;
   endtask

   // rise at the cursor, fall width later, then some low time
   task automatic push_pulse(input logic [pwfr_pkg::TIME_W-1:0] width);
      push_word(1'b0, 1'b1, line_clock);
      push_word(1'b0, 1'b0, line_clock + width);
      line_clock = line_clock + width + $urandom_range(1, 400);
      if ($urandom_range(0, 15) == 0) line_clock = $urandom;
   endtask

   // edges are favored
   function automatic logic [pwfr_pkg::TIME_W-1:0] pick_between(
         input logic [pwfr_pkg::TIME_W-1:0] lo, hi);
      case ($urandom_range(0, 7))
         0:       return lo;
         1:       return hi;
         default: return $urandom_range(hi, lo);
      endcase
   endfunction

   // caller makes sure the bit window is not empty
   function automatic logic [pwfr_pkg::TIME_W-1:0] bit_width(input logic want_one);
      logic [pwfr_pkg::TIME_W-1:0] th, zero_hi, one_lo;
      th      = pwfr_pkg::TIME_W'(cfg_thresh);
      one_lo  = (th > bit_lo()) ? th : bit_lo();
      zero_hi = (th == 0) ? '0 : ((th - 1 < bit_hi()) ? th - 1 : bit_hi());
      if ((want_one || th <= bit_lo()) && one_lo <= bit_hi())
         return pick_between(one_lo, bit_hi());
      return pick_between(bit_lo(), zero_hi);
   endfunction

   // start, nbits data bits, end pulse, then something that leaves the end phase;
   // mangled frames get stray clears and odd pulses mixed in
   task automatic send_frame(input int nbits, input bit mangle);
      logic [pwfr_pkg::TIME_W-1:0] end_min;
      end_min = (end_lo() > bit_hi()) ? end_lo() : bit_hi() + 1;
      push_pulse(pick_between(start_lo(), start_hi()));
      for (int i = 0; i < nbits; i++) begin
         if (mangle && $urandom_range(0, 19) == 0) begin
            if ($urandom_range(0, 3) == 0)
               push_word(1'b1, 1'($urandom_range(0, 1)), $urandom);
            else
               push_pulse($urandom_range(0, end_lo() + 30));
         end
         if (bit_lo() <= bit_hi()) push_pulse(bit_width(1'($urandom_range(0, 1))));
      end
      push_pulse(pick_between(end_min, end_min + 300));
      case ($urandom_range(0, 3))
         0:       push_word(1'b1, 1'($urandom_range(0, 1)), $urandom);
         1:       push_word(1'b0, 1'b0, line_clock);
         default: push_pulse($urandom_range(0, 500));
      endcase
   endtask

   task automatic random_words(input int unsigned count);
      int unsigned stop_at;
      int          pick;
      stop_at = words_queued + count;
      while (words_queued < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 65)
            send_frame(($urandom_range(0, 3) == 0) ? $urandom_range(0, 40)
                                                   : 8 * $urandom_range(1, 4), pick < 12);
         else if (pick < 80)
            push_pulse($urandom_range(0, start_hi() + 60));
         else
            push_word($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)),
                      $urandom_range(0, 1) ? $urandom : line_clock + $urandom_range(0, 200));
      end
   endtask

   // ---------------------------------------------------------------
   // Register writes, only while nothing is in flight
   // ---------------------------------------------------------------
   task automatic write_reg(input logic [pwfr_pkg::CSR_IDX_W-1:0] idx,
                            input logic [pwfr_pkg::CSR_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         pwfr_pkg::CSR_START_PULSE: cfg_start  = val;
         pwfr_pkg::CSR_ZERO_PULSE:  cfg_zero   = val;
         pwfr_pkg::CSR_ONE_PULSE:   cfg_one    = val;
         pwfr_pkg::CSR_END_PULSE:   cfg_end    = val;
         pwfr_pkg::CSR_BIT_THRESH:  cfg_thresh = val;
         default: ;
      endcase
   endtask

   // all five registers, then a write past the last index that must be ignored
   task automatic program_regs(input logic [pwfr_pkg::CSR_W-1:0] s, z, o, e, th);
      write_reg(pwfr_pkg::CSR_START_PULSE, s);
      write_reg(pwfr_pkg::CSR_ZERO_PULSE, z);
      write_reg(pwfr_pkg::CSR_ONE_PULSE, o);
      write_reg(pwfr_pkg::CSR_END_PULSE, e);
      write_reg(pwfr_pkg::CSR_BIT_THRESH, th);
      write_reg(pwfr_pkg::CSR_BIT_THRESH + pwfr_pkg::CSR_IDX_W'($urandom_range(1, 3)),
                pwfr_pkg::CSR_W'($urandom));
      csr_we <= 1'b0;
   endtask

   task automatic wait_quiet();
      while (words_taken != words_queued || decoded_q.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // Driver: bursts with gaps, holds the word until it is taken
   // ---------------------------------------------------------------
   int unsigned burst_left   = 0;
   int unsigned gap_left     = 0;
   logic        long_hold_on = 1'b0;  // no gaps while the result side is held off

   always @(posedge clock) begin : driver
      edge_word_type w;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            decoded_q.push_back(decode_edge(edge_word_type'{req_ch.command,
                                                            req_ch.line_level,
                                                            req_ch.time_us}));
            words_taken++;
         end
         if (!(req_ch.valid && !req_ch.ready)) begin
            if (gap_left > 0 && !long_hold_on) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (edge_words.size() > 0) begin
               w = edge_words.pop_front();
               req_ch.valid      <= 1'b1;
               req_ch.command    <= w.command;
               req_ch.line_level <= w.line_level;
               req_ch.time_us    <= w.time_us;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                           : $urandom_range(1, 30);
                  gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                           : $urandom_range(1, 5);
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Result side ready: stall modes that change now and then, plus
   // one long hold-off once the sender has a deep backlog
   // ---------------------------------------------------------------
   int unsigned hold_left      = 0;
   int unsigned mode_left      = 0;
   stall_type   stall_mode     = ALWAYS_READY;
   logic [7:0]  stall_mask     = 8'b1011_0110;
   bit          long_hold_done = 1'b0;

   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (!long_hold_done && words_taken > 200 && edge_words.size() > 100) begin
            hold_left      = LONG_HOLD;
            long_hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            long_hold_on = (hold_left != 0);
            rsp_ch.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               stall_mode = stall_type'($urandom_range(0, 3));
               mode_left  = $urandom_range(20, 300);
            end
            mode_left--;
            stall_mask = {stall_mask[6:0], stall_mask[7]};
            case (stall_mode)
               ALWAYS_READY:   rsp_ch.ready <= 1'b1;
               MOSTLY_READY:   rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               MOSTLY_STALLED: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
               default:        rsp_ch.ready <= stall_mask[0];
            endcase
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: every taken result word against the oldest prediction
   // ---------------------------------------------------------------
   int unsigned mismatches   = 0;
   int unsigned results_seen = 0;
   int unsigned bytes_seen   = 0;
   int unsigned starts_seen  = 0;
   int unsigned aborts_seen  = 0;

   always @(posedge clock) begin : monitor
      pwfr_pkg::rsp_type got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = {rsp_ch.phase, rsp_ch.byte_valid, rsp_ch.byte_value, rsp_ch.frame_started,
                rsp_ch.frame_done, rsp_ch.frame_aborted, rsp_ch.bytes_received};
         results_seen++;
         bytes_seen  += got.byte_valid;
         starts_seen += got.frame_started;
         aborts_seen += got.frame_aborted;
         if (decoded_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("result word %0d arrived with nothing predicted: %p", results_seen, got);
         end else begin
            want = decoded_q.pop_front();
            if (got.phase !== want.phase || got.byte_valid !== want.byte_valid ||
                got.byte_value !== want.byte_value || got.frame_started !== want.frame_started ||
                got.frame_done !== want.frame_done || got.frame_aborted !== want.frame_aborted ||
                got.bytes_received !== want.bytes_received) begin
               mismatches++;
               if (mismatches <= REPORT_MAX) begin
                  $display("word %0d exp ph %0d byte %0b/%02h st %0b dn %0b ab %0b n %0d",
                           results_seen, want.phase, want.byte_valid, want.byte_value,
                           want.frame_started, want.frame_done, want.frame_aborted,
                           want.bytes_received);
                  $display("word %0d got ph %0d byte %0b/%02h st %0b dn %0b ab %0b n %0d",
                           results_seen, got.phase, got.byte_valid, got.byte_value,
                           got.frame_started, got.frame_done, got.frame_aborted,
                           got.bytes_received);
               end
            end
         end
      end
   end

   // Watchdog
   int unsigned cycle_count = 0;

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------
   initial begin : sequencer
      logic [pwfr_pkg::CSR_W-1:0] z, o;
      req_ch.valid      = 1'b0;
      req_ch.command    = 1'b0;
      req_ch.line_level = 1'b0;
      req_ch.time_us    = '0;
      rsp_ch.ready      = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed words, reset register values: start 130..170, bits 25..85, end from 80
      push_word(1'b1, 1'b1, 32'hFFFF_FFFF);              // clear, other fields ignored
      push_word(1'b0, 1'b1, 32'hFFFF_FFF0);              // start pulse across the wrap, 154 us
      push_word(1'b0, 1'b0, 32'h0000_008A);
      line_clock = 32'h0000_0100;
      push_pulse(25);                                    // bit window low edge, zero
      push_pulse(85);                                    // bit window high edge, one
      push_pulse(55);                                    // exactly at threshold, one
      push_pulse(54);                                    // just under threshold, zero
      push_pulse(24);                                    // below window and end range: abort
      push_pulse(130);                                   // start window low edge
      push_pulse(86);                                    // just past bit window: frame end
      push_word(1'b0, 1'b0, line_clock);                 // lone falling edge back to idle
      push_word(1'b0, 1'b1, line_clock);                 // double rise, later one counts
      push_word(1'b0, 1'b1, line_clock + 5);
      push_word(1'b0, 1'b0, line_clock + 176);           // 171 us: too long for a start
      line_clock = line_clock + 1000;
      push_pulse(170);                                   // start window high edge
      push_word(1'b1, 1'b0, '0);                         // clear in the middle of a frame

      for (int setting = 0; setting < SETTING_COUNT; setting++) begin
         if (setting > 0) begin
            // sender stays quiet until every predicted word is back
            wait_quiet();
            repeat (4) @(posedge clock);
            case (setting)
               1: program_regs(16'd20, 16'd15, 16'd0, 16'd20, 16'd0);
               2: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
               3: begin
                  z = pwfr_pkg::CSR_W'($urandom_range(15, 200));
                  o = z + pwfr_pkg::CSR_W'($urandom_range(0, 200));
                  program_regs(pwfr_pkg::CSR_W'($urandom_range(20, 400)), z, o,
                               pwfr_pkg::CSR_W'($urandom_range(20, 600)),
                               pwfr_pkg::CSR_W'($urandom_range(o, z)));
               end
               default: program_regs(pwfr_pkg::CSR_W'(pwfr_pkg::START_RST),
                                     pwfr_pkg::CSR_W'(pwfr_pkg::ZERO_RST),
                                     pwfr_pkg::CSR_W'(pwfr_pkg::ONE_RST),
                                     pwfr_pkg::CSR_W'(pwfr_pkg::END_RST),
                                     pwfr_pkg::CSR_W'($urandom_range(0, 200)));
            endcase
         end
         random_words(RANDOM_WORDS);
         if (setting == 0) begin
            // one frame long enough to hit the byte limit and drop bits
            push_word(1'b1, 1'b0, $urandom);
            send_frame(FRAME_LIMIT * 8 + 11, 1'b0);
         end
      end

      wait_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (decoded_q.size() != 0) mismatches++;
      $display("Checked %0d result words for %0d edge words over %0d register settings.",
               results_seen, words_taken, SETTING_COUNT);
      $display("Saw %0d finished bytes, %0d frame starts and %0d aborted frames.",
               bytes_seen, starts_seen, aborts_seen);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
